>>> design/assert_macros.svh
// Assertion macros shared by the lexer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

>>> design/sclx_pkg.sv
// Types, character codes and helpers shared by the comment stripping lexer.
`timescale 1ns / 1ps

package sclx_pkg;

   // Port widths of the payload fields.
   localparam int CHAR_W = 16;
   localparam int LINE_W = 20;

   // Defaults for the top-level parameters.
   localparam int CHAR_BITS_DEF = 16;
   localparam int LINE_BITS_DEF = 20;

   // Results one item can cause, and the queue between front and back.
   localparam int MAX_RES     = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 16'h000A;
   localparam logic [CHAR_W-1:0] CH_DQUOTE    = 16'h0022;
   localparam logic [CHAR_W-1:0] CH_SQUOTE    = 16'h0027;
   localparam logic [CHAR_W-1:0] CH_STAR      = 16'h002A;
   localparam logic [CHAR_W-1:0] CH_SLASH     = 16'h002F;
   localparam logic [CHAR_W-1:0] CH_SEMI      = 16'h003B;
   localparam logic [CHAR_W-1:0] CH_UPPER_A   = 16'h0041;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 16'h005A;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
   localparam logic [CHAR_W-1:0] CH_LOWER_N   = 16'h006E;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 16'h0020;

   typedef enum logic [3:0] {
      ST_OK            = 4'd0,
      ST_NL_IN_CHAR    = 4'd1,
      ST_NL_IN_STRING  = 4'd2,
      ST_EMPTY_LITERAL = 4'd3,
      ST_BAD_ESCAPE    = 4'd4,
      ST_LITERAL_LONG  = 4'd5,
      ST_OPEN_LITERAL  = 4'd6,
      ST_OPEN_STRING   = 4'd7,
      ST_OPEN_BLOCK    = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SQ     = 3'd1,
      MODE_SQ_ESC = 3'd2,
      MODE_SQ_END = 3'd3,
      MODE_DQ     = 3'd4,
      MODE_DQ_ESC = 3'd5,
      MODE_LINE   = 3'd6,
      MODE_BLOCK  = 3'd7
   } mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              ch_valid;
      logic              done;
      status_type        status;
      logic [LINE_W-1:0] line;
   } res_type;

   // All results caused by one item, oldest in slot 0.
   typedef struct packed {
      res_type [MAX_RES-1:0] slot;
      logic [1:0]            count;
   } bundle_type;

   function automatic res_type mk_res(logic [CHAR_W-1:0] ch, logic vld, logic dn,
                                      status_type st, logic [LINE_W-1:0] ln);
      res_type r;
      r.ch       = ch;
      r.ch_valid = vld;
      r.done     = dn;
      r.status   = st;
      r.line     = ln;
      return r;
   endfunction

endpackage

>>> design/sclx_front.sv
// Front end: accepts characters, runs the lexer state and builds result bundles.
`timescale 1ns / 1ps

module sclx_front #(
   parameter int CHAR_BITS = sclx_pkg::CHAR_BITS_DEF,
   parameter int LINE_BITS = sclx_pkg::LINE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic [sclx_pkg::CHAR_W-1:0]     req_char_in,
   input  logic                            req_is_last,
   input  logic                            q_full,
   output logic                            push,
   output sclx_pkg::bundle_type            push_data
);
   import sclx_pkg::*;

   `include "assert_macros.svh"

   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

   mode_type             mode_ff, mode_in;
   logic                 slash_ff, slash_in;
   logic                 star_ff, star_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [LINE_BITS-1:0] block_ff, block_in;
   logic                 err_ff, err_in;
   status_type           ecode_ff, ecode_in;
   logic [LINE_BITS-1:0] eline_ff, eline_in;

   logic                 accept;
   logic                 lex_go;
   logic [CHAR_BITS-1:0] c;
   logic [1:0]           n;
   bundle_type           bnd;
   status_type           fin_status;
   logic [LINE_BITS-1:0] fin_line;

   assign accept = req_push && !q_full;
   assign c      = CHAR_BITS'(req_char_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         slash_ff <= 1'b0;
         star_ff  <= 1'b0;
         line_ff  <= LINE_ONE;
         block_ff <= LINE_ONE;
         err_ff   <= 1'b0;
         ecode_ff <= ST_OK;
         eline_ff <= LINE_ONE;
      end else begin
         mode_ff  <= mode_in;
         slash_ff <= slash_in;
         star_ff  <= star_in;
         line_ff  <= line_in;
         block_ff <= block_in;
         err_ff   <= err_in;
         ecode_ff <= ecode_in;
         eline_ff <= eline_in;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      slash_in   = slash_ff;
      star_in    = star_ff;
      line_in    = line_ff;
      block_in   = block_ff;
      err_in     = err_ff;
      ecode_in   = ecode_ff;
      eline_in   = eline_ff;
      lex_go     = 1'b0;
      n          = 2'd0;
      bnd        = '0;
      fin_status = ST_OK;
      fin_line   = line_ff;

      if (accept) begin
         if (!err_ff) begin
            lex_go = 1'b1;
            // A held slash either opens a comment or goes out ahead of this item.
            if (slash_ff) begin
               slash_in = 1'b0;
               if (c == CHAR_BITS'(CH_SLASH)) begin
                  mode_in = MODE_LINE;
                  lex_go  = 1'b0;
               end else if (c == CHAR_BITS'(CH_STAR)) begin
                  block_in = line_ff;
                  mode_in  = MODE_BLOCK;
                  star_in  = 1'b0;
                  lex_go   = 1'b0;
               end else begin
                  bnd.slot[n] = mk_res(CHAR_W'(CHAR_BITS'(CH_SLASH)), 1'b1, 1'b0, ST_OK,
                                       LINE_W'(line_ff));
                  n = n + 2'd1;
               end
            end

            if (lex_go) begin
               if (c == CHAR_BITS'(CH_NEWLINE)) begin
                  if (mode_ff inside {MODE_SQ, MODE_SQ_ESC, MODE_SQ_END}) begin
                     err_in   = 1'b1;
                     ecode_in = ST_NL_IN_CHAR;
                     eline_in = line_ff;
                     bnd.slot[n] = mk_res('0, 1'b0, 1'b0, ST_NL_IN_CHAR, LINE_W'(line_ff));
                     n = n + 2'd1;
                  end else if (mode_ff inside {MODE_DQ, MODE_DQ_ESC}) begin
                     err_in   = 1'b1;
                     ecode_in = ST_NL_IN_STRING;
                     eline_in = line_ff;
                     bnd.slot[n] = mk_res('0, 1'b0, 1'b0, ST_NL_IN_STRING, LINE_W'(line_ff));
                     n = n + 2'd1;
                  end else begin
                     if (mode_ff == MODE_LINE) begin
                        mode_in = MODE_NORMAL;
                     end
                     star_in = 1'b0;
                     bnd.slot[n] = mk_res(CHAR_W'(c), 1'b1, 1'b0, ST_OK, LINE_W'(line_ff));
                     n = n + 2'd1;
                     if (line_ff != LINE_MAX) begin
                        line_in = line_ff + LINE_ONE;
                     end
                  end
               end else begin
                  unique case (mode_ff)
                     MODE_NORMAL: begin
                        if (c == CHAR_BITS'(CH_SQUOTE)) begin
                           mode_in = MODE_SQ;
                           bnd.slot[n] = mk_res(CHAR_W'(c), 1'b1, 1'b0, ST_OK,
                                                LINE_W'(line_ff));
                           n = n + 2'd1;
                        end else if (c == CHAR_BITS'(CH_DQUOTE)) begin
                           mode_in = MODE_DQ;
                           bnd.slot[n] = mk_res(CHAR_W'(c), 1'b1, 1'b0, ST_OK,
                                                LINE_W'(line_ff));
                           n = n + 2'd1;
                        end else if (c == CHAR_BITS'(CH_SEMI)) begin
                           mode_in = MODE_LINE;
                        end else if (c == CHAR_BITS'(CH_SLASH)) begin
                           slash_in = 1'b1;
                        end else if (c >= CHAR_BITS'(CH_UPPER_A) &&
                                     c <= CHAR_BITS'(CH_UPPER_Z)) begin
                           bnd.slot[n] = mk_res(CHAR_W'(c + CHAR_BITS'(CASE_OFFSET)), 1'b1,
                                                1'b0, ST_OK, LINE_W'(line_ff));
                           n = n + 2'd1;
                        end else begin
                           bnd.slot[n] = mk_res(CHAR_W'(c), 1'b1, 1'b0, ST_OK,
                                                LINE_W'(line_ff));
                           n = n + 2'd1;
                        end
                     end
                     MODE_SQ: begin
                        if (c == CHAR_BITS'(CH_SQUOTE)) begin
                           err_in   = 1'b1;
                           ecode_in = ST_EMPTY_LITERAL;
                           eline_in = line_ff;
                           bnd.slot[n] = mk_res('0, 1'b0, 1'b0, ST_EMPTY_LITERAL,
                                                LINE_W'(line_ff));
                        end else begin
                           mode_in = (c == CHAR_BITS'(CH_BACKSLASH)) ? MODE_SQ_ESC
                                                                     : MODE_SQ_END;
                           bnd.slot[n] = mk_res(CHAR_W'(c), 1'b1, 1'b0, ST_OK,
                                                LINE_W'(line_ff));
                        end
                        n = n + 2'd1;
                     end
                     MODE_SQ_ESC, MODE_DQ_ESC: begin
                        if (c == CHAR_BITS'(CH_BACKSLASH) || c == CHAR_BITS'(CH_LOWER_N) ||
                            (mode_ff == MODE_SQ_ESC && c == CHAR_BITS'(CH_SQUOTE)) ||
                            (mode_ff == MODE_DQ_ESC && c == CHAR_BITS'(CH_DQUOTE))) begin
                           mode_in = (mode_ff == MODE_SQ_ESC) ? MODE_SQ_END : MODE_DQ;
                           bnd.slot[n] = mk_res(CHAR_W'(c), 1'b1, 1'b0, ST_OK,
                                                LINE_W'(line_ff));
                        end else begin
                           err_in   = 1'b1;
                           ecode_in = ST_BAD_ESCAPE;
                           eline_in = line_ff;
                           bnd.slot[n] = mk_res('0, 1'b0, 1'b0, ST_BAD_ESCAPE,
                                                LINE_W'(line_ff));
                        end
                        n = n + 2'd1;
                     end
                     MODE_SQ_END: begin
                        if (c == CHAR_BITS'(CH_SQUOTE)) begin
                           mode_in = MODE_NORMAL;
                           bnd.slot[n] = mk_res(CHAR_W'(c), 1'b1, 1'b0, ST_OK,
                                                LINE_W'(line_ff));
                        end else begin
                           err_in   = 1'b1;
                           ecode_in = ST_LITERAL_LONG;
                           eline_in = line_ff;
                           bnd.slot[n] = mk_res('0, 1'b0, 1'b0, ST_LITERAL_LONG,
                                                LINE_W'(line_ff));
                        end
                        n = n + 2'd1;
                     end
                     MODE_DQ: begin
                        if (c == CHAR_BITS'(CH_BACKSLASH)) begin
                           mode_in = MODE_DQ_ESC;
                        end else if (c == CHAR_BITS'(CH_DQUOTE)) begin
                           mode_in = MODE_NORMAL;
                        end
                        bnd.slot[n] = mk_res(CHAR_W'(c), 1'b1, 1'b0, ST_OK, LINE_W'(line_ff));
                        n = n + 2'd1;
                     end
                     MODE_LINE: begin
                     end
                     MODE_BLOCK: begin
                        // The star that opened the comment never counts toward closing it.
                        if (star_ff && c == CHAR_BITS'(CH_SLASH)) begin
                           mode_in = MODE_NORMAL;
                           star_in = 1'b0;
                        end else begin
                           star_in = (c == CHAR_BITS'(CH_STAR));
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         if (req_is_last) begin
            if (!err_in && slash_in) begin
               bnd.slot[n] = mk_res(CHAR_W'(CHAR_BITS'(CH_SLASH)), 1'b1, 1'b0, ST_OK,
                                    LINE_W'(line_in));
               n = n + 2'd1;
            end
            if (err_in) begin
               fin_status = ecode_in;
               fin_line   = eline_in;
            end else if (mode_in inside {MODE_SQ, MODE_SQ_ESC, MODE_SQ_END}) begin
               fin_status = ST_OPEN_LITERAL;
               fin_line   = line_in;
            end else if (mode_in inside {MODE_DQ, MODE_DQ_ESC}) begin
               fin_status = ST_OPEN_STRING;
               fin_line   = line_in;
            end else if (mode_in == MODE_BLOCK) begin
               fin_status = ST_OPEN_BLOCK;
               fin_line   = block_in;
            end else begin
               fin_status = ST_OK;
               fin_line   = line_in;
            end
            bnd.slot[n] = mk_res('0, 1'b0, 1'b1, fin_status, LINE_W'(fin_line));
            n = n + 2'd1;

            // The text is finished; the next item starts a fresh one.
            mode_in  = MODE_NORMAL;
            slash_in = 1'b0;
            star_in  = 1'b0;
            line_in  = LINE_ONE;
            block_in = LINE_ONE;
            err_in   = 1'b0;
            ecode_in = ST_OK;
            eline_in = LINE_ONE;
         end
      end

      bnd.count = n;
   end

   assign push      = accept && (n != 2'd0);
   assign push_data = bnd;

   `ASSERT_CLK(a_silent_after_error, clock, reset,
               (accept && err_ff && !req_is_last) |-> !push,
               "lexer produced a result after an error")
   `ASSERT_NEVER(a_line_nonzero, clock, reset, line_ff == '0,
                 "line counter wrapped to zero")

endmodule

>>> design/sclx_queue.sv
// Short bundle queue that decouples the lexer front from the output back end.
`timescale 1ns / 1ps

module sclx_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sclx_pkg::bundle_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output sclx_pkg::bundle_type head
);
   import sclx_pkg::*;

   `include "assert_macros.svh"

   localparam logic [Q_CNT_W-1:0] DEPTH_CNT = Q_CNT_W'(QUEUE_DEPTH);

   bundle_type         entry_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] occ_ff, occ_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (occ_ff == DEPTH_CNT);
   assign valid   = (occ_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         occ_in = occ_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         occ_in = occ_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_occ_bound, clock, reset, occ_ff > DEPTH_CNT,
                 "queue occupancy beyond its depth")
   `ASSERT_NEVER(a_push_when_full, clock, reset, push && full,
                 "bundle pushed into a full queue")

endmodule

>>> design/sclx_back.sv
// Back end: unpacks bundles into single results and holds the output register.
`timescale 1ns / 1ps

module sclx_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  sclx_pkg::bundle_type          head,
   output logic                          q_pop,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [sclx_pkg::CHAR_W-1:0]   rsp_char_out,
   output logic                          rsp_char_valid,
   output logic                          rsp_done_res,
   output sclx_pkg::status_type          rsp_status,
   output logic [sclx_pkg::LINE_W-1:0]   rsp_line_number
);
   import sclx_pkg::*;

   `include "assert_macros.svh"

   res_type    out_ff, out_in;
   logic       out_v_ff, out_v_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       last_slot;

   // The output register takes a new result whenever it is empty or being drained.
   assign load      = q_valid && (!out_v_ff || rsp_pop);
   assign last_slot = ((idx_ff + 2'd1) == head.count);
   assign q_pop     = load && last_slot;

   always_comb begin
      out_in   = out_ff;
      out_v_in = out_v_ff;
      idx_in   = idx_ff;
      if (load) begin
         out_in   = head.slot[idx_ff];
         out_v_in = 1'b1;
         idx_in   = last_slot ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         out_v_ff <= out_v_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty       = !out_v_ff;
   assign rsp_char_out    = out_ff.ch;
   assign rsp_char_valid  = out_ff.ch_valid;
   assign rsp_done_res    = out_ff.done;
   assign rsp_status      = out_ff.status;
   assign rsp_line_number = out_ff.line;

   `ASSERT_CLK(a_idx_in_bundle, clock, reset, q_valid |-> (idx_ff < head.count),
               "slot index past the end of the head bundle")
   `ASSERT_CLK(a_bundle_nonempty, clock, reset, q_valid |-> (head.count != 2'd0),
               "empty bundle at the queue head")

endmodule

>>> design/script_comment_strip_lexer.sv
// Top level of the script comment stripping lexer.
`timescale 1ns / 1ps

// Usage: text enters one character per item on the req_ queue port (push, full,
// char_in, is_last); an item is taken at a clock edge with push high and full low.
// Results leave on the rsp_ queue port: while empty is low the oldest result is on
// the rsp_ fields, and it is taken at an edge with pop high.
// Each item causes zero to three results: stripped characters, one error status and,
// on the item marked last, a final status with done_res set.
// With queue and output register empty, a result of an item is written into the queue
// entry first and reaches the rsp_ ports from the output register after that.
// Throughput: one item per cycle while items cause at most one result and the receiver
// pops; the output register moves one result per cycle, so an item with two or three
// results holds it for each one. A four-bundle queue between the lexer front and the
// output back end absorbs these bursts; full rises only when that queue is full.
// When the receiver stalls, the output register holds its result, the queue fills
// and then full stops further input. No item is lost.
// Reset clears the lexer to normal text on line 1 and empties queue and output.
// After the final status of a text the lexer is back in its reset state.

module script_comment_strip_lexer #(
   parameter int CHAR_BITS = sclx_pkg::CHAR_BITS_DEF,
   parameter int LINE_BITS = sclx_pkg::LINE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [sclx_pkg::CHAR_W-1:0] req_char_in,
   input  logic                        req_is_last,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [sclx_pkg::CHAR_W-1:0] rsp_char_out,
   output logic                        rsp_char_valid,
   output logic                        rsp_done_res,
   output sclx_pkg::status_type        rsp_status,
   output logic [sclx_pkg::LINE_W-1:0] rsp_line_number
);
   import sclx_pkg::*;

   logic       q_full;
   logic       q_push;
   bundle_type q_push_data;
   logic       q_valid;
   logic       q_pop;
   bundle_type q_head;

   assign req_full = q_full;

   sclx_front #(
      .CHAR_BITS (CHAR_BITS),
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_char_in (req_char_in),
      .req_is_last (req_is_last),
      .q_full      (q_full),
      .push        (q_push),
      .push_data   (q_push_data)
   );

   sclx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   sclx_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .head            (q_head),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_char_out    (rsp_char_out),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_done_res    (rsp_done_res),
      .rsp_status      (rsp_status),
      .rsp_line_number (rsp_line_number)
   );

endmodule
